// ----- rtl/fixed_string_line_filter_core_macros.svh -----
// Assertion macros used by the line filter packer.
// Each macro expects clk and rst to be visible in the module that uses it.
`ifndef FIXED_STRING_LINE_FILTER_CORE_MACROS_SVH
`define FIXED_STRING_LINE_FILTER_CORE_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define FSLF_CHECK_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define FSLF_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/fslf_pkg.sv -----
// Package for the fixed-string line filter: payload types, register map,
// state encoding and default sizes. No dependencies.
package fslf_pkg;

  localparam int LINE_MAX_DEFAULT    = 80;
  localparam int PATTERN_MAX_DEFAULT = 16;
  localparam int BEAT_BYTES_DEFAULT  = 8;

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 64;
  localparam int PLEN_W  = 5;

  localparam logic [7:0] NEWLINE_BYTE = 8'd10;

  localparam logic [1:0] REG_PATTERN_LOW  = 2'd0;
  localparam logic [1:0] REG_PATTERN_HIGH = 2'd1;
  localparam logic [1:0] REG_PATTERN_LEN  = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [63:0] out_bytes;
    logic [3:0]  byte_count;
    logic        last_beat;
  } out_item_t;

  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } ctrl_state_t;

endpackage

// ----- rtl/fslf_chunk_ram.sv -----
// Chunk byte store: one write port, one registered read port.
// Depends on nothing but its parameters.
module fslf_chunk_ram #(
  parameter int Depth = 80,
  parameter int AddrW = 7
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [7:0]       wr_data,
  input  logic             rd_en,
  input  logic [AddrW-1:0] rd_addr,
  output logic [7:0]       rd_data
);

  logic [7:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/fslf_matcher.sv -----
// Sliding window of recent chunk bytes and the pattern comparison.
// Uses fslf_pkg for the pattern length width.
module fslf_matcher import fslf_pkg::*; #(
  parameter int PatternMax = PATTERN_MAX_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              clear,
  input  logic [7:0]        in_byte,
  input  logic [63:0]       pattern_low,
  input  logic [63:0]       pattern_high,
  input  logic [PLEN_W-1:0] plen,
  input  logic              enough,
  output logic              hit_now,
  output logic              match_seen
);

  logic [PatternMax-1:0][7:0] win;
  logic [PatternMax-1:0][7:0] win_next;
  logic [15:0][7:0]           pat_bytes;

  assign pat_bytes = {pattern_high, pattern_low};

  always_comb begin
    logic [5:0] off;
    logic [5:0] k;
    for (int j = 0; j < PatternMax - 1; j++) begin
      win_next[j] = win[j+1];
    end
    win_next[PatternMax-1] = in_byte;
    hit_now = enough && (plen != '0);
    for (int j = 0; j < PatternMax; j++) begin
      off = 6'(j) + 6'(plen);
      k   = off - 6'(PatternMax);
      if (off >= 6'(PatternMax)) begin
        if (win_next[j] != pat_bytes[k[3:0]]) begin
          hit_now = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      win        <= '0;
      match_seen <= 1'b0;
    end else if (step) begin
      win <= win_next;
      if (hit_now) begin
        match_seen <= 1'b1;
      end
    end
  end

endmodule

// ----- rtl/fslf_packer.sv -----
// Output engine: reads a matched chunk from the store, appends a newline and
// packs the bytes into beats held in an output register. Uses fslf_pkg.
`include "fixed_string_line_filter_core_macros.svh"

module fslf_packer import fslf_pkg::*; #(
  parameter int LineMax   = LINE_MAX_DEFAULT,
  parameter int BeatBytes = BEAT_BYTES_DEFAULT
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              start,
  input  logic [$clog2(LineMax+1)-1:0]                      start_len,
  output logic                                              rd_en,
  output logic [((LineMax > 1) ? $clog2(LineMax) : 1)-1:0]  rd_addr,
  input  logic [7:0]                                        rd_data,
  output logic                                              busy,
  output logic                                              result_valid,
  input  logic                                              result_ready,
  output out_item_t                                         result
);

  localparam int LW = $clog2(LineMax + 1);
  localparam int AW = (LineMax > 1) ? $clog2(LineMax) : 1;
  localparam int FW = $clog2(BeatBytes + 1);

  logic [LW-1:0] len;
  logic [LW-1:0] req_pos;
  logic          req_done;
  logic          pend;
  logic          pend_nl;
  logic [FW-1:0] fill;
  logic [63:0]   asm_bytes;
  logic          held;
  logic          held_last;

  logic          can_issue;
  logic [7:0]    in_b;
  logic [63:0]   asm_next;
  logic [FW-1:0] fill_next;
  logic          complete;
  logic          push;
  logic          push_last;

  always_comb begin
    can_issue = busy && !req_done && !held &&
                (({1'b0, fill} + (FW+1)'(pend)) < (FW+1)'(BeatBytes));
    rd_en     = can_issue && (req_pos != len);
    rd_addr   = req_pos[AW-1:0];
    in_b      = pend_nl ? NEWLINE_BYTE : rd_data;
    asm_next  = asm_bytes;
    if (pend) begin
      for (int i = 0; i < BeatBytes; i++) begin
        if (fill == FW'(i)) begin
          asm_next[8*i +: 8] = in_b;
        end
      end
    end
    fill_next = fill + FW'(pend);
    complete  = pend && ((fill_next == FW'(BeatBytes)) || pend_nl);
    push      = busy && (complete || held) && (!result_valid || result_ready);
    push_last = held ? held_last : pend_nl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      pend         <= 1'b0;
      held         <= 1'b0;
      req_done     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (push) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (start) begin
        busy     <= 1'b1;
        pend     <= 1'b0;
        held     <= 1'b0;
        req_done <= 1'b0;
      end else if (busy) begin
        pend <= can_issue;
        if (can_issue && (req_pos == len)) begin
          req_done <= 1'b1;
        end
        if (push) begin
          held <= 1'b0;
          if (push_last) begin
            busy <= 1'b0;
          end
        end else if (complete) begin
          held <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      len       <= start_len;
      req_pos   <= '0;
      fill      <= '0;
      asm_bytes <= '0;
    end else if (busy) begin
      pend_nl <= (req_pos == len);
      if (can_issue && (req_pos != len)) begin
        req_pos <= req_pos + 1'b1;
      end
      if (push) begin
        result.out_bytes  <= asm_next;
        result.byte_count <= 4'(fill_next);
        result.last_beat  <= push_last;
        fill              <= '0;
        asm_bytes         <= '0;
      end else if (complete) begin
        held_last <= pend_nl;
        asm_bytes <= asm_next;
        fill      <= fill_next;
      end else if (pend) begin
        asm_bytes <= asm_next;
        fill      <= fill_next;
      end
    end
  end

  `FSLF_CHECK_IMPL(a_start_when_idle, start, !busy, "Drain started while busy.")
  `FSLF_CHECK_IMPL(a_read_in_chunk, rd_en, req_pos < len, "Read past chunk end.")
  `FSLF_CHECK_IMPL(a_pend_room, pend, fill < FW'(BeatBytes), "Byte arrived with full beat.")
  `FSLF_CHECK_NEXT(a_last_frees, push && push_last, !busy, "Engine busy after last beat.")

endmodule

// ----- rtl/fixed_string_line_filter_core.sv -----
// Input bytes are taken at one byte per cycle while the controller fills. A matched
// chunk then holds off input while the packer reads its len stored bytes, appends a
// newline and packs them into beats until the last beat enters the output register,
// longer while result transfers stall. Reset is synchronous and clears the control
// state, registers and window; the chunk store itself is not cleared.
module fixed_string_line_filter_core import fslf_pkg::*; #(
  parameter int LineMax    = LINE_MAX_DEFAULT,
  parameter int PatternMax = PATTERN_MAX_DEFAULT,
  parameter int BeatBytes  = BEAT_BYTES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  in_item_t           item,
  output logic               result_valid,
  input  logic               result_ready,
  output out_item_t          result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int LW   = $clog2(LineMax + 1);
  localparam int AW   = (LineMax > 1) ? $clog2(LineMax) : 1;
  localparam int CMPW = (LW > PLEN_W) ? LW : PLEN_W;

  logic [63:0]       pattern_low;
  logic [63:0]       pattern_high;
  logic [PLEN_W-1:0] pattern_len;
  logic [PLEN_W-1:0] plen_used;

  ctrl_state_t state;
  ctrl_state_t state_next;

  logic [LW-1:0] chunk_length;
  logic [LW-1:0] cl_inc;
  logic          accept;
  logic          is_nl;
  logic          take;
  logic          close;
  logic          enough;
  logic          hit_now;
  logic          match_seen;
  logic          start;
  logic [LW-1:0] start_len;
  logic          busy;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic          cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low  <= '0;
      pattern_high <= '0;
      pattern_len  <= '0;
    end else if (cfg_write) begin
      case (paddr[4:3])
        REG_PATTERN_LOW:  pattern_low  <= pwdata;
        REG_PATTERN_HIGH: pattern_high <= pwdata;
        REG_PATTERN_LEN:  pattern_len  <= pwdata[PLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      REG_PATTERN_LOW:  prdata = pattern_low;
      REG_PATTERN_HIGH: prdata = pattern_high;
      REG_PATTERN_LEN:  prdata = PDATA_W'(pattern_len);
      default:          prdata = '0;
    endcase
  end

  assign plen_used = (pattern_len > PLEN_W'(PatternMax)) ? PLEN_W'(PatternMax) : pattern_len;

  always_comb begin
    item_ready = (state == ST_FILL);
    accept     = item_valid && item_ready;
    is_nl      = (item.in_byte == NEWLINE_BYTE);
    take       = accept && !item.end_of_input && !is_nl;
    cl_inc     = chunk_length + 1'b1;
    enough     = CMPW'(cl_inc) >= CMPW'(plen_used);
    close      = accept && (item.end_of_input || is_nl ||
                            (take && (cl_inc == LW'(LineMax))));
    start      = close && (match_seen || (take && hit_now) || (plen_used == '0));
    start_len  = take ? cl_inc : chunk_length;
    state_next = state;
    case (state)
      ST_FILL: begin
        if (start) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!busy) begin
          state_next = ST_FILL;
        end
      end
      default: state_next = ST_FILL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_FILL;
      chunk_length <= '0;
    end else begin
      state <= state_next;
      if (close) begin
        chunk_length <= '0;
      end else if (take) begin
        chunk_length <= cl_inc;
      end
    end
  end

  fslf_chunk_ram #(
    .Depth (LineMax),
    .AddrW (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (take),
    .wr_addr (chunk_length[AW-1:0]),
    .wr_data (item.in_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  fslf_matcher #(
    .PatternMax (PatternMax)
  ) u_matcher (
    .clk          (clk),
    .rst          (rst),
    .step         (take),
    .clear        (close),
    .in_byte      (item.in_byte),
    .pattern_low  (pattern_low),
    .pattern_high (pattern_high),
    .plen         (plen_used),
    .enough       (enough),
    .hit_now      (hit_now),
    .match_seen   (match_seen)
  );

  fslf_packer #(
    .LineMax   (LineMax),
    .BeatBytes (BeatBytes)
  ) u_packer (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .start_len    (start_len),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .busy         (busy),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ----- bench/fixed_string_line_filter_core_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for fixed_string_line_filter_core: drives byte transfers
// and APB pattern writes, predicts the output beats and checks each one.
// Depends on fslf_pkg and the core RTL only.
module fixed_string_line_filter_core_tb import fslf_pkg::*;;

  localparam int unsigned SETTLE_CYCLES = 150;
  localparam int unsigned QUIET_LIMIT   = 4000;
  localparam int unsigned PHASE_ITEMS   = 45;
  localparam int unsigned PHASE_COUNT   = 9;

  class line_grep_scoreboard;
    logic [7:0]  line_buf [LINE_MAX_DEFAULT];
    int unsigned line_len;
    bit          hit_seen;
    logic [7:0]  tail [PATTERN_MAX_DEFAULT];
    logic [63:0] pat_low;
    logic [63:0] pat_high;
    logic [4:0]  pat_len;
    out_item_t   pending_beats [$];
    int unsigned mismatches;

    function new();
      pat_low    = '0;
      pat_high   = '0;
      pat_len    = '0;
      mismatches = 0;
      restart_line();
    endfunction

    function int unsigned active_len();
      return (pat_len > PATTERN_MAX_DEFAULT) ? PATTERN_MAX_DEFAULT : pat_len;
    endfunction

    function logic [7:0] pat_byte(int unsigned k);
      return (k < 8) ? pat_low[8*k +: 8] : pat_high[8*(k-8) +: 8];
    endfunction

    function void restart_line();
      line_len = 0;
      hit_seen = 1'b0;
      foreach (tail[i]) tail[i] = 8'h00;
    endfunction

    function void write_reg(logic [1:0] idx, logic [63:0] val);
      case (idx)
        REG_PATTERN_LOW: pat_low = val;
        REG_PATTERN_HIGH: pat_high = val;
        REG_PATTERN_LEN: pat_len = val[PLEN_W-1:0];
        default: ;
      endcase
    endfunction

    function void add_byte(logic [7:0] b);
      int unsigned plen;
      bit hit;
      plen = active_len();
      line_buf[line_len] = b;
      line_len++;
      for (int i = 0; i < PATTERN_MAX_DEFAULT - 1; i++) tail[i] = tail[i+1];
      tail[PATTERN_MAX_DEFAULT-1] = b;
      if (plen == 0 || line_len < plen) return;
      hit = 1'b1;
      for (int unsigned k = 0; k < plen; k++) begin
        if (tail[PATTERN_MAX_DEFAULT-plen+k] != pat_byte(k)) hit = 1'b0;
      end
      if (hit) hit_seen = 1'b1;
    endfunction

    function void close_line();
      int unsigned total;
      int unsigned pos;
      int unsigned cnt;
      out_item_t beat;
      if (hit_seen || active_len() == 0) begin
        total = line_len + 1;
        pos = 0;
        while (pos < total) begin
          cnt = total - pos;
          if (cnt > BEAT_BYTES_DEFAULT) cnt = BEAT_BYTES_DEFAULT;
          beat.out_bytes = '0;
          for (int unsigned b = 0; b < cnt; b++) begin
            beat.out_bytes[8*b +: 8] = (pos + b < line_len) ? line_buf[pos+b] : NEWLINE_BYTE;
          end
          pos += cnt;
          beat.byte_count = cnt[3:0];
          beat.last_beat = (pos >= total);
          pending_beats.push_back(beat);
        end
      end
      restart_line();
    endfunction

    function void take_transfer(in_item_t it);
      if (it.end_of_input || it.in_byte == NEWLINE_BYTE) begin
        close_line();
      end else begin
        add_byte(it.in_byte);
        if (line_len >= LINE_MAX_DEFAULT) close_line();
      end
    endfunction

    function void check_beat(out_item_t got);
      out_item_t want;
      if (pending_beats.size() == 0) begin
        $error("unexpected result transfer: out_bytes %h byte_count %0d last_beat %0b",
               got.out_bytes, got.byte_count, got.last_beat);
        mismatches++;
        return;
      end
      want = pending_beats.pop_front();
      if (got.out_bytes !== want.out_bytes) begin
        $error("out_bytes: expected %h, got %h", want.out_bytes, got.out_bytes);
        mismatches++;
      end
      if (got.byte_count !== want.byte_count) begin
        $error("byte_count: expected %0d, got %0d", want.byte_count, got.byte_count);
        mismatches++;
      end
      if (got.last_beat !== want.last_beat) begin
        $error("last_beat: expected %0b, got %0b", want.last_beat, got.last_beat);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_ready;
  in_item_t           item = '0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  out_item_t          result;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  line_grep_scoreboard board;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned quiet_cycles = 0;

  fixed_string_line_filter_core dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(negedge clk) begin
    result_ready <= !rst && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) board.check_beat(result);
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic apb_write(input logic [1:0] idx, input logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.write_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic load_pattern(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [4:0] n);
    apb_write(REG_PATTERN_LOW, lo);
    apb_write(REG_PATTERN_HIGH, hi);
    apb_write(REG_PATTERN_LEN, {59'd0, n});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_item(input logic [7:0] b, input logic eoi);
    in_item_t it;
    it.in_byte = b;
    it.end_of_input = eoi;
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (!item_ready);
    board.take_transfer(it);
    @(negedge clk);
  endtask

  task automatic drain_and_settle();
    item_valid <= 1'b0;
    while (board.pending_beats.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic send_lines(input int unsigned budget);
    int unsigned sent;
    int unsigned len;
    int unsigned plen;
    int unsigned at;
    int unsigned pick;
    logic [7:0] line [$];
    logic [7:0] b;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        repeat ($urandom_range(1, 6)) begin
          if (sent < budget) begin
            send_item(8'($urandom_range(255)), $urandom_range(9) == 0);
            sent++;
          end
        end
      end else begin
        len = ($urandom_range(19) == 0) ? $urandom_range(78, 90) : $urandom_range(0, 20);
        line.delete();
        repeat (len) begin
          b = 8'($urandom_range(255));
          if (b == NEWLINE_BYTE) b = b ^ 8'h01;
          line.push_back(b);
        end
        plen = board.active_len();
        if (plen > 0 && plen <= len && $urandom_range(99) < 60) begin
          at = $urandom_range(0, len - plen);
          for (int unsigned k = 0; k < plen; k++) line[at+k] = board.pat_byte(k);
          if ($urandom_range(9) == 0) line[at+plen-1] = line[at+plen-1] ^ 8'h80;
        end
        foreach (line[i]) begin
          if (sent < budget) begin
            send_item(line[i], 1'b0);
            sent++;
          end
        end
        pick = $urandom_range(99);
        if (sent < budget && pick < 80) begin
          send_item(NEWLINE_BYTE, 1'b0);
          sent++;
        end else if (sent < budget && pick < 92) begin
          send_item(8'($urandom_range(255)), 1'b1);
          sent++;
        end
      end
    end
  endtask

  initial begin
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  n;
    board = new();
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle_pct = 35;
    recv_idle_pct = 64;
    load_pattern({48'h0, 8'hFF, 8'h00}, 64'h0, 5'd2);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h41, 1'b0);
    send_item(NEWLINE_BYTE, 1'b0);
    send_item(NEWLINE_BYTE, 1'b0);
    send_item(8'hFF, 1'b1);
    for (int i = 1; i <= 7; i++) send_item(8'(i * 37), 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(NEWLINE_BYTE, 1'b0);
    send_item(8'h7F, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'hAA, 1'b1);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h55, 1'b1);
    send_item(8'h00, 1'b0);

    for (int unsigned p = 0; p < PHASE_COUNT; p++) begin
      send_idle_pct = (p < 3) ? 35 : (p < 6) ? 64 : 0;
      recv_idle_pct = (p < 3) ? 64 : (p < 6) ? 35 : 0;
      lo = {$urandom, $urandom};
      hi = {$urandom, $urandom};
      case (p)
        0: begin n = 5'd0; lo = '0; hi = '0; end
        1: n = 5'd1;
        2: begin n = 5'd16; lo = '1; hi = '1; end
        3: n = 5'd31;
        4: n = 5'd3;
        5: n = 5'd17;
        6: n = 5'd5;
        7: begin n = 5'd2; lo[15:8] = NEWLINE_BYTE; end
        default: n = 5'd8;
      endcase
      drain_and_settle();
      load_pattern(lo, hi, n);
      send_lines(PHASE_ITEMS);
    end

    drain_and_settle();
    if (board.pending_beats.size() != 0) begin
      $error("%0d expected result transfers never arrived", board.pending_beats.size());
    end
    if (board.mismatches == 0 && board.pending_beats.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/fslf_pkg.sv
rtl/fslf_chunk_ram.sv
rtl/fslf_matcher.sv
rtl/fslf_packer.sv
rtl/fixed_string_line_filter_core.sv
bench/fixed_string_line_filter_core_tb.sv
